// ===== design/asc_pkg.sv =====
package asc_pkg;

    // field widths
    localparam int POS_W     = 24;
    localparam int DIFF_W    = 25;
    localparam int RAD_W     = 23;
    localparam int SPD_W     = 24;
    localparam int DIR_W     = 16;
    localparam int SQ_W      = 49;
    localparam int PROD_W    = 48;
    localparam int ROOT_W    = 25;
    localparam int DIVR_W    = 26;
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 56;

    // quotient bits produced by the divider for each use
    localparam int SPD_QW = 24;
    localparam int DIR_QW = 15;

    // square root iterations, one result bit each
    localparam int SQRT_STEPS = ROOT_W;

    // configuration register indexes
    localparam logic CFG_TARGET_RADIUS = 1'b0;
    localparam logic CFG_SLOW_RADIUS   = 1'b1;

    // multiplier operand select
    localparam logic [2:0] MUL_UX  = 3'd0;
    localparam logic [2:0] MUL_UY  = 3'd1;
    localparam logic [2:0] MUL_TR  = 3'd2;
    localparam logic [2:0] MUL_SR  = 3'd3;
    localparam logic [2:0] MUL_SPD = 3'd4;

    // divider operand select
    localparam logic [1:0] DIV_SPD = 2'd0;
    localparam logic [1:0] DIV_DX  = 2'd1;
    localparam logic [1:0] DIV_DY  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       sum_init;
        logic       sum_add;
        logic       arr_chk;
        logic       slow_chk;
        logic       sqrt_start;
        logic       sqrt_step;
        logic       div_start;
        logic [1:0] div_sel;
        logic       div_step;
        logic       speed_full;
        logic       take_speed;
        logic       take_dx;
        logic       take_dy;
        logic       out_load;
    } asc_cmd_t;

    typedef struct packed {
        logic arrived;
        logic slow;
        logic sqrt_last;
        logic div_last;
    } asc_sts_t;

endpackage

// ===== design/arrive_speed_scaling_core.sv =====
// one item at a time: a new transaction is taken only after the previous result is loaded;
// arrived items skip the 25-step square root and the shared 24/15-step divider, and items
// outside the slow radius skip the speed division and go straight to the direction steps
// the output register holds one finished result, so the next item is taken while it waits
// reset: aresetn synchronous active low; clears both radii, the captured full speed,
// the controller state and m_tvalid
module arrive_speed_scaling_core (
    input  logic                          aclk,
    input  logic                          aresetn,

    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // agent_x[23:0], agent_y[47:24], target_x[71:48], target_y[95:72],
    // current_speed_limit[119:96]
    input  logic [asc_pkg::S_TDATA_W-1:0] s_tdata,

    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // dir_x[15:0], dir_y[31:16], speed_limit[55:32]
    output logic [asc_pkg::M_TDATA_W-1:0] m_tdata,
    // arrived[0]
    output logic                          m_tuser,

    // configuration writes: index 0 target_radius, index 1 slow_radius
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [asc_pkg::RAD_W-1:0]     cfg_wdata
);
    import asc_pkg::*;

    // command and status between sequencer and datapath
    asc_cmd_t cmd;
    asc_sts_t sts;

    // sequencer: walks squares, radius compares, root and up to three divisions,
    // and owns the result transaction handshake
    asc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: one shared 24x24 multiplier, bit-serial square root,
    // restoring divider, radius registers and the result payload register
    asc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== design/asc_div.sv =====
module asc_div (
    input  logic                       aclk,
    input  logic                       start,
    input  logic                       step,
    input  logic                       narrow,
    input  logic [asc_pkg::PROD_W-1:0] dividend,
    input  logic [asc_pkg::DIVR_W-1:0] divisor,
    output logic [asc_pkg::SPD_QW-1:0] quotient,
    output logic                       last
);
    import asc_pkg::*;

    logic [DIVR_W-1:0] rem_reg,  rem_next;
    logic [SPD_QW-1:0] low_reg,  low_next;
    logic [SPD_QW-1:0] quo_reg,  quo_next;
    logic [DIVR_W-1:0] dvs_reg,  dvs_next;
    logic [4:0]        cnt_reg,  cnt_next;
    logic [DIVR_W:0]   trial;
    logic [DIVR_W:0]   diff;
    logic              fits;

    // restoring division, one quotient bit a cycle while step is high
    assign trial = {rem_reg, low_reg[SPD_QW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        rem_next = rem_reg;
        low_next = low_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        if (start) begin
            dvs_next = divisor;
            quo_next = '0;
            if (narrow) begin
                rem_next = dividend[DIR_QW+DIVR_W-1:DIR_QW];
                low_next = {dividend[DIR_QW-1:0], {(SPD_QW-DIR_QW){1'b0}}};
                cnt_next = 5'(DIR_QW - 1);
            end else begin
                rem_next = {{(DIVR_W-(PROD_W-SPD_QW)){1'b0}}, dividend[PROD_W-1:SPD_QW]};
                low_next = dividend[SPD_QW-1:0];
                cnt_next = 5'(SPD_QW - 1);
            end
        end else if (step) begin
            rem_next = fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
            low_next = {low_reg[SPD_QW-2:0], 1'b0};
            quo_next = {quo_reg[SPD_QW-2:0], fits};
            cnt_next = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    assign quotient = quo_reg;
    assign last     = (cnt_reg == 5'd0);

endmodule

// ===== design/asc_dp.sv =====
module asc_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [asc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [asc_pkg::RAD_W-1:0]     cfg_wdata,
    input  asc_pkg::asc_cmd_t             cmd,
    output asc_pkg::asc_sts_t             sts,
    output logic [asc_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tuser
);
    import asc_pkg::*;

    logic [RAD_W-1:0]   tr_reg, sr_reg;
    logic [SPD_W-1:0]   full_reg;
    logic               captured_reg;

    logic [DIFF_W-1:0]  dx_reg, dy_reg;
    logic [POS_W-1:0]   ux, uy;
    logic [DIFF_W-1:0]  dx_neg, dy_neg;
    logic [DIFF_W-1:0]  dx_next, dy_next;

    logic [POS_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]  p_reg;
    logic [SQ_W-1:0]    s_reg;
    logic               arr_reg, slow_reg;

    logic [2*ROOT_W-1:0] sq_bits_reg;
    logic [DIVR_W-1:0]  sq_rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [4:0]         sq_cnt_reg;
    logic [DIVR_W+1:0]  sq_t;
    logic [DIVR_W:0]    sq_trial;
    logic               sq_fits;

    logic [ROOT_W-1:0]  d_less_tr;
    logic [RAD_W-1:0]   sr_less_tr;

    logic [PROD_W-1:0]  div_dividend;
    logic [DIVR_W-1:0]  div_divisor;
    logic               div_narrow;
    logic [SPD_QW-1:0]  div_q;
    logic               div_last;
    logic [DIR_W-1:0]   q_dir;

    logic [SPD_W-1:0]   speed_reg;
    logic [DIR_W-1:0]   dirx_reg, diry_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic               m_tuser_reg;

    // position differences, target minus agent
    assign dx_next = {s_tdata[71], s_tdata[71:48]} - {s_tdata[23], s_tdata[23:0]};
    assign dy_next = {s_tdata[95], s_tdata[95:72]} - {s_tdata[47], s_tdata[47:24]};

    assign dx_neg = -dx_reg;
    assign dy_neg = -dy_reg;
    assign ux = dx_reg[DIFF_W-1] ? dx_neg[POS_W-1:0] : dx_reg[POS_W-1:0];
    assign uy = dy_reg[DIFF_W-1] ? dy_neg[POS_W-1:0] : dy_reg[POS_W-1:0];

    assign d_less_tr  = root_reg - {{(ROOT_W-RAD_W){1'b0}}, tr_reg};
    assign sr_less_tr = sr_reg - tr_reg;

    always_comb begin
        case (cmd.mul_sel)
            MUL_UX: begin
                mul_a = ux;
                mul_b = ux;
            end
            MUL_UY: begin
                mul_a = uy;
                mul_b = uy;
            end
            MUL_TR: begin
                mul_a = {1'b0, tr_reg};
                mul_b = {1'b0, tr_reg};
            end
            MUL_SR: begin
                mul_a = {1'b0, sr_reg};
                mul_b = {1'b0, sr_reg};
            end
            MUL_SPD: begin
                mul_a = full_reg;
                mul_b = d_less_tr[POS_W-1:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // square root step, two radicand bits in, one root bit out
    assign sq_t     = {sq_rem_reg, sq_bits_reg[2*ROOT_W-1:2*ROOT_W-2]};
    assign sq_trial = {root_reg, 2'b01};
    assign sq_fits  = (sq_t >= {1'b0, sq_trial});

    always_comb begin
        case (cmd.div_sel)
            DIV_SPD: begin
                div_dividend = p_reg;
                div_divisor  = {{(DIVR_W-RAD_W){1'b0}}, sr_less_tr};
                div_narrow   = 1'b0;
            end
            DIV_DX: begin
                div_dividend = {{(PROD_W-POS_W-DIR_QW){1'b0}}, ux, {DIR_QW{1'b0}}}
                    + {{(PROD_W-ROOT_W){1'b0}}, root_reg};
                div_divisor  = {root_reg, 1'b0};
                div_narrow   = 1'b1;
            end
            DIV_DY: begin
                div_dividend = {{(PROD_W-POS_W-DIR_QW){1'b0}}, uy, {DIR_QW{1'b0}}}
                    + {{(PROD_W-ROOT_W){1'b0}}, root_reg};
                div_divisor  = {root_reg, 1'b0};
                div_narrow   = 1'b1;
            end
            default: begin
                div_dividend = '0;
                div_divisor  = '0;
                div_narrow   = 1'b0;
            end
        endcase
    end

    asc_div u_div (
        .aclk     (aclk),
        .start    (cmd.div_start),
        .step     (cmd.div_step),
        .narrow   (div_narrow),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .last     (div_last)
    );

    assign q_dir = {{(DIR_W-DIR_QW){1'b0}}, div_q[DIR_QW-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tr_reg       <= '0;
            sr_reg       <= '0;
            full_reg     <= '0;
            captured_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_TARGET_RADIUS: tr_reg <= cfg_wdata;
                    CFG_SLOW_RADIUS:   sr_reg <= cfg_wdata;
                    default:           tr_reg <= tr_reg;
                endcase
            end
            if (cmd.load && !captured_reg) begin
                full_reg     <= s_tdata[119:96];
                captured_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (cmd.mul_en) begin
            p_reg <= mul_a * mul_b;
        end
        if (cmd.sum_init) begin
            s_reg <= {1'b0, p_reg};
        end else if (cmd.sum_add) begin
            s_reg <= s_reg + {1'b0, p_reg};
        end
        if (cmd.arr_chk) begin
            arr_reg <= (s_reg <= {1'b0, p_reg});
        end
        if (cmd.slow_chk) begin
            slow_reg <= (s_reg <= {1'b0, p_reg});
        end
        if (cmd.sqrt_start) begin
            sq_bits_reg <= {1'b0, s_reg};
            sq_rem_reg  <= '0;
            root_reg    <= '0;
            sq_cnt_reg  <= '0;
        end else if (cmd.sqrt_step) begin
            sq_bits_reg <= {sq_bits_reg[2*ROOT_W-3:0], 2'b00};
            sq_rem_reg  <= sq_fits ? DIVR_W'(sq_t - {1'b0, sq_trial}) : sq_t[DIVR_W-1:0];
            root_reg    <= {root_reg[ROOT_W-2:0], sq_fits};
            sq_cnt_reg  <= sq_cnt_reg + 5'd1;
        end
        if (cmd.speed_full) begin
            speed_reg <= full_reg;
        end else if (cmd.take_speed) begin
            speed_reg <= div_q;
        end
        if (cmd.take_dx) begin
            dirx_reg <= dx_reg[DIFF_W-1] ? -q_dir : q_dir;
        end
        if (cmd.take_dy) begin
            diry_reg <= dy_reg[DIFF_W-1] ? -q_dir : q_dir;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= arr_reg ? '0 : {speed_reg, diry_reg, dirx_reg};
            m_tuser_reg <= arr_reg;
        end
    end

    assign sts.arrived   = arr_reg;
    assign sts.slow      = slow_reg;
    assign sts.sqrt_last = (sq_cnt_reg == 5'(SQRT_STEPS - 1));
    assign sts.div_last  = div_last;

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

// ===== design/asc_ctrl.sv =====
module asc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  asc_pkg::asc_sts_t sts,
    output asc_pkg::asc_cmd_t cmd
);
    import asc_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SQX    = 4'd1;
    localparam logic [3:0] ST_SQY    = 4'd2;
    localparam logic [3:0] ST_TR     = 4'd3;
    localparam logic [3:0] ST_SR     = 4'd4;
    localparam logic [3:0] ST_CMP    = 4'd5;
    localparam logic [3:0] ST_SQRT   = 4'd6;
    localparam logic [3:0] ST_SMUL   = 4'd7;
    localparam logic [3:0] ST_SPD    = 4'd8;
    localparam logic [3:0] ST_SDIV   = 4'd9;
    localparam logic [3:0] ST_SDONE  = 4'd10;
    localparam logic [3:0] ST_DX     = 4'd11;
    localparam logic [3:0] ST_DXDONE = 4'd12;
    localparam logic [3:0] ST_DY     = 4'd13;
    localparam logic [3:0] ST_DYDONE = 4'd14;
    localparam logic [3:0] ST_OUT    = 4'd15;

    logic [3:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;

    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SQX;
                end
            end
            ST_SQX: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_UX;
                state_next  = ST_SQY;
            end
            ST_SQY: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_UY;
                cmd.sum_init = 1'b1;
                state_next   = ST_TR;
            end
            ST_TR: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_TR;
                cmd.sum_add = 1'b1;
                state_next  = ST_SR;
            end
            ST_SR: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SR;
                cmd.arr_chk = 1'b1;
                state_next  = ST_CMP;
            end
            ST_CMP: begin
                cmd.slow_chk = 1'b1;
                if (sts.arrived) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT;
                end
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (sts.sqrt_last) begin
                    state_next = ST_SMUL;
                end
            end
            ST_SMUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SPD;
                state_next  = ST_SPD;
            end
            ST_SPD: begin
                cmd.div_start = 1'b1;
                if (sts.slow) begin
                    cmd.div_sel = DIV_SPD;
                    state_next  = ST_SDIV;
                end else begin
                    cmd.speed_full = 1'b1;
                    cmd.div_sel    = DIV_DX;
                    state_next     = ST_DX;
                end
            end
            ST_SDIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_SDONE;
                end
            end
            ST_SDONE: begin
                cmd.take_speed = 1'b1;
                cmd.div_start  = 1'b1;
                cmd.div_sel    = DIV_DX;
                state_next     = ST_DX;
            end
            ST_DX: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_DXDONE;
                end
            end
            ST_DXDONE: begin
                cmd.take_dx   = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_DY;
                state_next    = ST_DY;
            end
            ST_DY: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_DYDONE;
                end
            end
            ST_DYDONE: begin
                cmd.take_dy = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== design/asc_chk.sv =====
module asc_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [asc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);

    // a stalled result holds still
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one item in flight: no transaction right after one is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    // arrived results carry zero direction and zero speed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("arrived result not zero");

    // direction components stay within one in Q1.14
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384)
            && ($signed(m_tdata[15:0]) >= -16'sd16384)
            && ($signed(m_tdata[31:16]) <= 16'sd16384)
            && ($signed(m_tdata[31:16]) >= -16'sd16384))
        else $error("direction out of range");

endmodule

bind arrive_speed_scaling_core asc_chk u_asc_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
